/* hw/rtl/longest_prefix_match_lookup_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the longest prefix match lookup block.
// Full forms in simulation, empty bodies when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_MATCH_LOOKUP_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_LOOKUP_DEFINES_SVH
`ifndef SYNTHESIS
// Plain property, clocked and disabled in reset.
`define LPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication: pre |-> post.
`define LPM_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define LPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPM_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

/* hw/rtl/lpm_pkg.sv */
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared widths, codes and types of the longest prefix match lookup.
// ----------------------------------------------------------------------------
package lpm_pkg;

  localparam int unsigned DEPTH_DEF = 1024;

  localparam int unsigned IDX_W     = 10;
  localparam int unsigned IP_W      = 32;
  localparam int unsigned PORT_W    = 8;
  localparam int unsigned TBL_LEN_W = 11;

  // APB side: one 32-bit register, word address in paddr[CFG_AW-1:2]
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_TABLE_LENGTH = 1'b0;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  // one routing table row as held in the RAM
  typedef struct packed {
    logic [IP_W-1:0]   prefix;
    logic [IP_W-1:0]   mask;
    logic [PORT_W-1:0] port;
  } entry_t;

endpackage

/* hw/rtl/lpm_if.sv */
// ----------------------------------------------------------------------------
// lpm_in_if / lpm_out_if
// Valid/ready channels of the lookup: request items in, lookup results out.
// ----------------------------------------------------------------------------
interface lpm_in_if;
  logic                         valid;
  logic                         ready;
  lpm_pkg::op_t                 operation;
  logic [lpm_pkg::IDX_W-1:0]    entry_index;
  logic [lpm_pkg::IP_W-1:0]     entry_prefix;
  logic [lpm_pkg::IP_W-1:0]     entry_mask;
  logic [lpm_pkg::PORT_W-1:0]   entry_port;
  logic [lpm_pkg::IP_W-1:0]     lookup_addr;

  modport source (
    output valid, operation, entry_index, entry_prefix, entry_mask, entry_port, lookup_addr,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, entry_prefix, entry_mask, entry_port, lookup_addr,
    output ready
  );
endinterface

interface lpm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [lpm_pkg::PORT_W-1:0]   out_port;
  logic [lpm_pkg::IP_W-1:0]     best_mask;

  modport source (
    output valid, found, out_port, best_mask,
    input  ready
  );
  modport sink (
    input  valid, found, out_port, best_mask,
    output ready
  );
endinterface

/* hw/rtl/lpm_ram.sv */
// ----------------------------------------------------------------------------
// lpm_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = lpm_pkg::DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/longest_prefix_match_lookup.sv */
// ----------------------------------------------------------------------------
// longest_prefix_match_lookup
// Write item: RAM written at the transfer, ready stays high. Lookup item with
// L = min(table_length, DEPTH): rows 0 .. L-1 scanned, then the result is
// registered; one table row read per cycle from the single RAM port.
// Next item taken when the result is registered, even while it waits.
// Sync active-low reset clears control and table_length; table RAM keeps junk.
// ----------------------------------------------------------------------------
`include "longest_prefix_match_lookup_defines.svh"

module longest_prefix_match_lookup #(
  parameter int unsigned DEPTH = lpm_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lpm_in_if.sink                       in_chan,
  lpm_out_if.source                    out_chan,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [lpm_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [lpm_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [lpm_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  // RAM address bits, and scan counter bits (counter must hold DEPTH itself)
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration: table_length at word 0. Byte offset bits are don't care.
  // --------------------------------------------------------------------------
  logic [lpm_pkg::TBL_LEN_W-1:0] table_len_r;
  logic                          cfg_hit;
  logic                          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[lpm_pkg::CFG_AW-1:2] == lpm_pkg::REG_TABLE_LENGTH);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & cfg_hit;
  assign cfg_prdata = cfg_hit ? lpm_pkg::CFG_DW'(table_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_len_r <= '0;
    end else if (cfg_wr) begin
      table_len_r <= cfg_pwdata[lpm_pkg::TBL_LEN_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Control and scan state
  // --------------------------------------------------------------------------
  state_t                     state_r,     state_nxt;
  logic [CW-1:0]              rd_cnt_r,    rd_cnt_nxt;
  logic [CW-1:0]              limit_r,     limit_nxt;
  logic                       rd_vld_r,    rd_vld_nxt;   // RAM data valid this cycle
  logic [lpm_pkg::IP_W-1:0]   dest_r,      dest_nxt;
  logic                       hit_r,       hit_nxt;
  logic [lpm_pkg::IP_W-1:0]   best_mask_r, best_mask_nxt;
  logic [lpm_pkg::PORT_W-1:0] best_port_r, best_port_nxt;

  // registered result, parts the scan from the output channel
  logic                       out_valid_r, out_valid_nxt;
  logic                       found_r,     found_nxt;
  logic [lpm_pkg::PORT_W-1:0] port_r,      port_nxt;
  logic [lpm_pkg::IP_W-1:0]   mask_r,      mask_nxt;

  logic            in_xfer;
  logic            wr_ok;
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  lpm_pkg::entry_t ram_wdata;
  lpm_pkg::entry_t ram_rdata;
  logic            issue;
  logic            match;
  logic            better;
  logic            take;
  logic            res_load;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid & in_chan.ready;

  // slots at or past DEPTH are dropped
  assign wr_ok  = (32'(in_chan.entry_index) < DEPTH);
  assign ram_we = in_xfer & (in_chan.operation == lpm_pkg::OP_WRITE) & wr_ok;

  assign ram_wdata.prefix = in_chan.entry_prefix;
  assign ram_wdata.mask   = in_chan.entry_mask;
  assign ram_wdata.port   = in_chan.entry_port;

  // one read per scan cycle until the limit is reached; writes only ever happen in idle
  assign issue    = (state_r == ST_SCAN) && (rd_cnt_r < limit_r);
  assign ram_addr = (state_r == ST_SCAN) ? rd_cnt_r[AW-1:0] : AW'(in_chan.entry_index);

  lpm_ram #(
    .WIDTH ($bits(lpm_pkg::entry_t)),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Single compare unit: prefix match plus mask-versus-best compare.
  // First match always taken (default route with mask 0 included),
  // later ones only on a strictly larger mask.
  assign match  = ((dest_r & ram_rdata.mask) == (ram_rdata.prefix & ram_rdata.mask));
  assign better = !hit_r || (ram_rdata.mask > best_mask_r);
  assign take   = rd_vld_r & match & better;

  // result register free, or emptied by a transfer in this cycle
  assign res_load = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt     = state_r;
    rd_cnt_nxt    = rd_cnt_r;
    limit_nxt     = limit_r;
    rd_vld_nxt    = issue;
    dest_nxt      = dest_r;
    hit_nxt       = hit_r;
    best_mask_nxt = best_mask_r;
    best_port_nxt = best_port_r;

    if (take) begin
      hit_nxt       = 1'b1;
      best_mask_nxt = ram_rdata.mask;
      best_port_nxt = ram_rdata.port;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_chan.operation == lpm_pkg::OP_LOOKUP)) begin
          state_nxt     = ST_SCAN;
          dest_nxt      = in_chan.lookup_addr;
          rd_cnt_nxt    = '0;
          hit_nxt       = 1'b0;
          best_mask_nxt = '0;
          best_port_nxt = '0;
          // clamp length to the table depth
          if (32'(table_len_r) > DEPTH) begin
            limit_nxt = CW'(DEPTH);
          end else begin
            limit_nxt = CW'(table_len_r);
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end else if (!rd_vld_r) begin
          // last row compared
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_chan.ready;
    found_nxt     = found_r;
    port_nxt      = port_r;
    mask_nxt      = mask_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      found_nxt     = hit_r;
      port_nxt      = best_port_r;
      mask_nxt      = best_mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt_r    <= rd_cnt_nxt;
    limit_r     <= limit_nxt;
    dest_r      <= dest_nxt;
    hit_r       <= hit_nxt;
    best_mask_r <= best_mask_nxt;
    best_port_r <= best_port_nxt;
    found_r     <= found_nxt;
    port_r      <= port_nxt;
    mask_r      <= mask_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.found     = found_r;
  assign out_chan.out_port  = port_r;
  assign out_chan.best_mask = mask_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LPM_ASSERT_IMPL(a_res_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_DONE), "result without finished scan")
  `LPM_ASSERT_IMPL(a_we_idle_only, clk, rst_n, ram_we, state_r == ST_IDLE, "table write during scan")
  `LPM_ASSERT_IMPL(a_cnt_in_range, clk, rst_n, state_r == ST_SCAN, rd_cnt_r <= limit_r, "scan counter past limit")
  `LPM_ASSERT_IMPL(a_no_hit_clean, clk, rst_n, (state_r == ST_SCAN) && !hit_r, (best_mask_r == '0) && (best_port_r == '0), "best entry set without a hit")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: longest prefix match lookup testbench
// Loads routing entries through write items and checks every lookup result
// against an in-bench route predictor or a typed result: a short directed
// table first, then random phases at changing table lengths. Both channel
// sides idle at random; table_length is set over APB.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned IDX_W     = lpm_pkg::IDX_W;
  localparam int unsigned IP_W      = lpm_pkg::IP_W;
  localparam int unsigned PORT_W    = lpm_pkg::PORT_W;
  localparam int unsigned TBL_LEN_W = lpm_pkg::TBL_LEN_W;
  localparam int unsigned CFG_AW    = lpm_pkg::CFG_AW;
  localparam int unsigned CFG_DW    = lpm_pkg::CFG_DW;

  localparam int unsigned TBL_DEPTH   = lpm_pkg::DEPTH_DEF;
  localparam int unsigned RAND_ITEMS  = 580;
  localparam int unsigned STALL_LIMIT = 20000;  // cycles without any transfer
  localparam int unsigned IDLE_PCT    = 38;
  localparam int unsigned MAX_SHOWN   = 10;

  // byte addresses of the single register and of an unused slot next to it
  localparam logic [CFG_AW-1:0] ADDR_TABLE_LENGTH = {lpm_pkg::REG_TABLE_LENGTH, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_UNUSED       = {~lpm_pkg::REG_TABLE_LENGTH, 2'b00};

  typedef struct packed {
    logic              found;
    logic [PORT_W-1:0] port;
    logic [IP_W-1:0]   mask;
  } route_result_t;

  typedef struct {
    lpm_pkg::op_t      op;
    logic [IDX_W-1:0]  idx;
    logic [IP_W-1:0]   prefix;
    logic [IP_W-1:0]   mask;
    logic [PORT_W-1:0] port;
    logic [IP_W-1:0]   dest;
  } route_req_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  // one line of the directed table: an item, or a register write
  typedef struct {
    row_kind_t         kind;
    route_req_t        req;
    bit                typed;       // expected result written in by hand
    route_result_t     typed_res;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_data;
  } plan_row_t;

  localparam route_result_t NO_ROUTE      = '0;
  localparam route_result_t ALL_ONES_HOST = {1'b1, 8'hFF, 32'hFFFF_FFFF};

  logic clk;
  logic rst_n;

  lpm_in_if  in_chan ();
  lpm_out_if out_chan ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  longest_prefix_match_lookup u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Route predictor state: bench copy of the table and of table_length.
  // route_written tracks which rows may be scanned without reading junk.
  // --------------------------------------------------------------------------
  logic [IP_W-1:0]      route_prefix  [TBL_DEPTH];
  logic [IP_W-1:0]      route_mask    [TBL_DEPTH];
  logic [PORT_W-1:0]    route_port    [TBL_DEPTH];
  bit                   route_written [TBL_DEPTH];
  logic [TBL_LEN_W-1:0] route_len;

  route_result_t pending_routes[$];   // lookup results still owed by the DUT
  plan_row_t     plan[$];             // directed table
  logic [IP_W-1:0] addr_pool[4];      // shared bases so prefixes overlap
  int unsigned   mismatches;
  bit            steady;              // no idling on either side while set

  // best match over rows 0 .. min(table_length, depth)-1; first match is
  // always taken, later ones only with a strictly larger mask
  function automatic route_result_t predict_route(logic [IP_W-1:0] dest);
    route_result_t r;
    int unsigned   lim;
    r   = NO_ROUTE;
    lim = (route_len > TBL_DEPTH) ? TBL_DEPTH : route_len;
    for (int unsigned i = 0; i < lim; i++) begin
      if ((dest & route_mask[i]) == (route_prefix[i] & route_mask[i])) begin
        if (!r.found || route_mask[i] > r.mask) begin
          r.found = 1'b1;
          r.mask  = route_mask[i];
          r.port  = route_port[i];
        end
      end
    end
    return r;
  endfunction

  function automatic int unsigned contiguous_written();
    int unsigned k;
    k = 0;
    while (k < TBL_DEPTH && route_written[k]) k++;
    return k;
  endfunction

  // ---- directed table builders ----
  function automatic void add_write(logic [IDX_W-1:0] idx, logic [IP_W-1:0] prefix,
                                    logic [IP_W-1:0] mask, logic [PORT_W-1:0] port);
    plan_row_t row;
    row = '{kind: ROW_ITEM, typed: 1'b0, typed_res: NO_ROUTE, cfg_addr: '0, cfg_data: '0,
            req: '{op: lpm_pkg::OP_WRITE, idx: idx, prefix: prefix, mask: mask,
                   port: port, dest: ~prefix}};   // dest is don't-care on a write
    plan.push_back(row);
  endfunction

  function automatic void add_lookup(logic [IP_W-1:0] dest, bit typed,
                                     route_result_t typed_res);
    plan_row_t row;
    // entry fields carry junk: a lookup must ignore them
    row = '{kind: ROW_ITEM, typed: typed, typed_res: typed_res, cfg_addr: '0,
            cfg_data: '0,
            req: '{op: lpm_pkg::OP_LOOKUP, idx: ~dest[IDX_W-1:0], prefix: ~dest,
                   mask: dest, port: dest[PORT_W-1:0], dest: dest}};
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    plan_row_t row;
    row = '{kind: ROW_CFG, typed: 1'b0, typed_res: NO_ROUTE, cfg_addr: addr,
            cfg_data: data,
            req: '{op: lpm_pkg::OP_WRITE, idx: '0, prefix: '0, mask: '0, port: '0,
                   dest: '0}};
    plan.push_back(row);
  endfunction

  // ---- random item makers ----
  function automatic route_req_t gen_route_write(int unsigned idx_hi);
    route_req_t      r;
    logic [IP_W-1:0] base;
    r.op   = lpm_pkg::OP_WRITE;
    // mostly near the filled front so the scannable table grows
    r.idx  = ($urandom_range(0, 99) < 80) ? IDX_W'($urandom_range(0, idx_hi))
                                          : IDX_W'($urandom);
    case ($urandom_range(0, 9))
      0:       r.mask = '0;                                  // default route
      1:       r.mask = $urandom;                            // non-contiguous
      default: r.mask = ~(32'hFFFF_FFFF >> $urandom_range(0, 32));
    endcase
    base = ($urandom_range(0, 3) == 0) ? $urandom : addr_pool[$urandom_range(0, 3)];
    // host bits left dirty half the time: the compare masks both sides
    r.prefix = $urandom_range(0, 1) ? (base & r.mask) : ((base & r.mask) | ($urandom & ~r.mask));
    r.port   = PORT_W'($urandom);
    r.dest   = $urandom;
    return r;
  endfunction

  function automatic route_req_t gen_route_lookup();
    route_req_t  r;
    int unsigned lim;
    int unsigned j;
    lim      = (route_len > TBL_DEPTH) ? TBL_DEPTH : route_len;
    r.op     = lpm_pkg::OP_LOOKUP;
    r.idx    = IDX_W'($urandom);
    r.prefix = $urandom;
    r.mask   = $urandom;
    r.port   = PORT_W'($urandom);
    if (lim > 0 && $urandom_range(0, 99) < 75) begin
      // aim inside some entry's subnet, random host part
      j      = $urandom_range(0, lim - 1);
      r.dest = (route_prefix[j] & route_mask[j]) | ($urandom & ~route_mask[j]);
    end else if ($urandom_range(0, 1)) begin
      r.dest = addr_pool[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(0, 31));
    end else begin
      r.dest = $urandom;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [IP_W-1:0] exp_v, logic [IP_W-1:0] act_v);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
  endtask

  // --------------------------------------------------------------------------
  // Input side: random gap, then hold valid until the transfer. The table
  // copy and the expected result are updated at the accepting edge, so
  // items are predicted in exactly the order the DUT takes them.
  // --------------------------------------------------------------------------
  task automatic send_item(input route_req_t req, input bit typed,
                           input route_result_t typed_res);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.operation    <= req.op;
    in_chan.entry_index  <= req.idx;
    in_chan.entry_prefix <= req.prefix;
    in_chan.entry_mask   <= req.mask;
    in_chan.entry_port   <= req.port;
    in_chan.lookup_addr  <= req.dest;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    if (req.op == lpm_pkg::OP_WRITE) begin
      route_prefix[req.idx]  = req.prefix;
      route_mask[req.idx]    = req.mask;
      route_port[req.idx]    = req.port;
      route_written[req.idx] = 1'b1;
    end else begin
      pending_routes.push_back(typed ? typed_res : predict_route(req.dest));
    end
  endtask

  // APB setup + access, then psel dropped before the next access so psel never toggles twice in a step
  task automatic cfg_access(input bit wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // write a register, then read table_length back against the bench copy
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    logic [CFG_DW-1:0] rd;
    cfg_access(1'b1, addr, data, rd);
    if (addr == ADDR_TABLE_LENGTH) route_len = data[TBL_LEN_W-1:0];
    cfg_access(1'b0, ADDR_TABLE_LENGTH, '0, rd);
    if (rd !== CFG_DW'(route_len)) flag_mismatch("table_length readback", route_len, rd);
  endtask

  // table_length with junk above its 11 bits
  task automatic set_table_length(input int unsigned len);
    write_reg(ADDR_TABLE_LENGTH, ($urandom & ~32'h7FF) | CFG_DW'(len));
  endtask

  // block idle: every lookup answered, plus slack for a trailing table write
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side backpressure: ready drops ~38% of cycles except when steady
  // --------------------------------------------------------------------------
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each transfer against the oldest expected lookup result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    route_result_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_routes.size() == 0) begin
        flag_mismatch("unexpected result (mask shown)", '0, out_chan.best_mask);
      end else begin
        want = pending_routes.pop_front();
        if (out_chan.found !== want.found)
          flag_mismatch("found", want.found, out_chan.found);
        if (out_chan.out_port !== want.port)
          flag_mismatch("out_port", want.port, out_chan.out_port);
        if (out_chan.best_mask !== want.mask)
          flag_mismatch("best_mask", want.mask, out_chan.best_mask);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a long quiet spell with no transfer anywhere, well beyond a
  // full-depth scan, means the DUT has hung
  // --------------------------------------------------------------------------
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) || cfg_psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    plan_row_t   row;
    route_req_t  req;
    int unsigned rand_items;
    int unsigned phase_no;
    int unsigned filled;
    int unsigned next_len;
    int unsigned n;

    mismatches = 0;
    steady     = 1'b0;
    route_len  = '0;
    foreach (route_written[i]) route_written[i] = 1'b0;

    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.operation    <= lpm_pkg::OP_WRITE;
    in_chan.entry_index  <= '0;
    in_chan.entry_prefix <= '0;
    in_chan.entry_mask   <= '0;
    in_chan.entry_port   <= '0;
    in_chan.lookup_addr  <= '0;
    cfg_psel             <= 1'b0;
    cfg_penable          <= 1'b0;
    cfg_pwrite           <= 1'b0;
    cfg_paddr            <= '0;
    cfg_pwdata           <= '0;

    // ---- directed table ----
    // empty table right after reset: no route for either address extreme
    add_lookup(32'h0000_0000, 1'b1, NO_ROUTE);
    add_lookup(32'hFFFF_FFFF, 1'b1, NO_ROUTE);
    add_write(10'd0,    32'h0000_0000, 32'h0000_0000, 8'h11);  // default route
    add_write(10'd1,    32'h0A00_0000, 32'hFF00_0000, 8'h22);  // 10/8
    add_write(10'd2,    32'h0A01_0000, 32'hFFFF_0000, 8'h33);  // 10.1/16
    add_write(10'd3,    32'h0A01_FFFF, 32'hFFFF_0000, 8'h44);  // same /16: loses the tie
    add_write(10'd4,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);  // all-ones host
    add_write(10'd5,    32'h0012_0034, 32'h00FF_00FF, 8'h55);  // non-contiguous mask
    add_write(10'd6,    32'hC0A8_0100, 32'hFFFF_FF00, 8'h00);
    add_write(10'd7,    32'h0000_0000, 32'hFFFF_FFFF, 8'h80);  // host route 0.0.0.0
    add_write(10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);  // last slot
    add_cfg(ADDR_TABLE_LENGTH, 32'hFFFF_F808);                  // length 8, junk above
    add_lookup(32'h0A01_0203, 1'b0, NO_ROUTE);
    add_lookup(32'h0A02_0000, 1'b0, NO_ROUTE);
    add_lookup(32'h0102_0304, 1'b0, NO_ROUTE);
    add_lookup(32'hFFFF_FFFF, 1'b1, ALL_ONES_HOST);
    add_lookup(32'h0000_0000, 1'b0, NO_ROUTE);
    add_lookup(32'hAB12_CD34, 1'b0, NO_ROUTE);
    add_lookup(32'hC0A8_0105, 1'b0, NO_ROUTE);
    add_cfg(ADDR_UNUSED, 32'h0000_0000);                         // must not touch length
    add_lookup(32'h0A01_FFFF, 1'b0, NO_ROUTE);
    add_cfg(ADDR_TABLE_LENGTH, 32'h0000_0001);                  // only the default route
    add_lookup(32'h0A01_0203, 1'b0, NO_ROUTE);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.cfg_addr, row.cfg_data);
      end else begin
        send_item(row.req, row.typed, row.typed_res);
      end
    end
    settle();

    // ---- random phases: new table_length each, never past the filled front ----
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    rand_items = 0;
    phase_no   = 0;
    while (rand_items < RAND_ITEMS) begin
      steady = (phase_no == 2 || phase_no == 3);
      filled = contiguous_written();
      case ($urandom_range(0, 5))
        0:       next_len = 0;
        1:       next_len = (filled > 0) ? 1 : 0;
        2, 3:    next_len = filled;
        default: next_len = $urandom_range(0, filled);
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(ADDR_UNUSED, $urandom);
      set_table_length(next_len);
      n = $urandom_range(20, 60);
      repeat (n) begin
        if ($urandom_range(0, 99) < 30)
          req = gen_route_write((filled + 4 > TBL_DEPTH - 1) ? TBL_DEPTH - 1 : filled + 4);
        else
          req = gen_route_lookup();
        send_item(req, 1'b0, NO_ROUTE);
        rand_items++;
      end
      settle();
      phase_no++;
    end
    steady = 1'b0;

    // ---- drain and verdict ----
    settle();
    repeat (32) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
